/* rtl/srgbld_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srgbld_pkg
// Shared types, constants and helpers for the serial RGB LED chain driver.
// ---------------------------------------------------------------------------
package srgbld_pkg;

    // Chain size and pixel store layout: one row of the store holds one LED.
    localparam int LED_TOTAL = 64;
    localparam int LED_AW    = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
    localparam int CH_W      = 7;
    localparam int ROW_W     = 3 * CH_W;

    // Colour scaling: c * b / 200 is done as c * (b * 5243) >> 20, which is
    // exact for every product below 25600.
    localparam int BRIGHT_RECIP = 5243;
    localparam int BRIGHT_SHIFT = 20;
    localparam int FACTOR_W     = 20;
    localparam int COLOUR_W     = 8;
    localparam int PROD_W       = COLOUR_W + FACTOR_W;
    localparam int BRIGHT_W     = 7;
    localparam int BRIGHT_MAX   = 100;

    // Configuration port.
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;
    localparam int TICK_W = 16;

    localparam logic [2:0] REG_ZERO_HIGH   = 3'd0;
    localparam logic [2:0] REG_ZERO_PERIOD = 3'd1;
    localparam logic [2:0] REG_ONE_HIGH    = 3'd2;
    localparam logic [2:0] REG_ONE_PERIOD  = 3'd3;
    localparam logic [2:0] REG_LATCH       = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS  = 3'd5;

    localparam logic [TICK_W-1:0]   RST_ZERO_HIGH   = 16'd18;
    localparam logic [TICK_W-1:0]   RST_ZERO_PERIOD = 16'd126;
    localparam logic [TICK_W-1:0]   RST_ONE_HIGH    = 16'd108;
    localparam logic [TICK_W-1:0]   RST_ONE_PERIOD  = 16'd130;
    localparam logic [TICK_W-1:0]   RST_LATCH       = 16'd21600;
    localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS  = 7'd100;
    localparam logic [FACTOR_W-1:0] RST_FACTOR      = FACTOR_W'(100 * BRIGHT_RECIP);

    // Item commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Colour position within an LED, in transmission order.
    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_BITS  = 3'b010,
        PH_LATCH = 3'b100
    } phase_t;

    // Picks one bit of one colour byte out of a stored row. Bit seven of a
    // stored byte is always zero.
    function automatic logic row_bit(input logic [ROW_W-1:0] row,
                                     input logic [1:0]       col,
                                     input logic [2:0]       bitn);
        logic [7:0] b;
        case (col)
            COL_RED:   b = {1'b0, row[3*CH_W-1 -: CH_W]};
            COL_GREEN: b = {1'b0, row[2*CH_W-1 -: CH_W]};
            default:   b = {1'b0, row[CH_W-1 -: CH_W]};
        endcase
        return b[bitn];
    endfunction

endpackage
`default_nettype wire

/* rtl/srgbld_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srgbld_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
// ---------------------------------------------------------------------------
module srgbld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/serial_rgb_led_chain_driver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// serial_rgb_led_chain_driver
// One-wire RGB LED chain driver with a scaled pixel store and a bit timer.
// ---------------------------------------------------------------------------
//  channel  | signals                                 | transfer when
//  ---------+-----------------------------------------+-----------------------
//  item     | item_valid, item_stall, cmd, led_index, | item_valid & !item_stall
//           | red_in, green_in, blue_in               |
//  result   | result_valid, result_stall, line_level, | result_valid & !result_stall
//           | busy_res, frame_done                    |
//  config   | psel, penable, pwrite, paddr, pwdata,   | psel & penable & pwrite
//           | prdata, pready                          |
//
// Each accepted item yields one result in the next cycle; the block takes
// one item per cycle with no gaps unless the result is stalled. The pixel
// store is a RAM of one row per LED; the row being sent and the next one are
// held in registers and refilled by reads, kept current by forwarding of
// pixel writes. Reset clears all control state and the row valid bits, so
// unwritten rows read as zero; no clearing pass is needed. A stalled result
// holds the input side, since the result register is the only buffer.
// ---------------------------------------------------------------------------
module serial_rgb_led_chain_driver (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [1:0]                     cmd,
    input  wire logic [5:0]                     led_index,
    input  wire logic [7:0]                     red_in,
    input  wire logic [7:0]                     green_in,
    input  wire logic [7:0]                     blue_in,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic                                line_level,
    output logic                                busy_res,
    output logic                                frame_done,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [srgbld_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [srgbld_pkg::CFG_DW-1:0]  pwdata,
    output logic      [srgbld_pkg::CFG_DW-1:0]  prdata,
    output logic                                pready
);

    import srgbld_pkg::*;

    // Configuration registers.
    logic [TICK_W-1:0]   zero_high_reg;
    logic [TICK_W-1:0]   zero_period_reg;
    logic [TICK_W-1:0]   one_high_reg;
    logic [TICK_W-1:0]   one_period_reg;
    logic [TICK_W-1:0]   latch_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [FACTOR_W-1:0] factor_reg;

    // Frame state.
    phase_t              phase_reg,    phase_next;
    logic [LED_AW-1:0]   led_reg,      led_next;
    logic [1:0]          col_reg,      col_next;
    logic [2:0]          bit_reg,      bit_next;
    logic [TICK_W-1:0]   tick_reg,     tick_next;
    logic                cur_bit_reg,  cur_bit_next;
    logic                line_reg,     line_next;
    logic                done_reg,     done_next;
    logic                res_vld_reg,  res_vld_next;

    // Row buffers and fetch tracking.
    logic [ROW_W-1:0]    cur_row_reg,  cur_row_next;
    logic [ROW_W-1:0]    nxt_row_reg,  nxt_row_next;
    logic                cur_pend_reg, cur_pend_next;
    logic                nxt_pend_reg, nxt_pend_next;
    logic [LED_AW-1:0]   rd_addr_reg,  rd_addr_next;
    logic                ovr_reg,      ovr_next;
    logic [LED_TOTAL-1:0] row_vld_reg;

    logic                cfg_we;
    logic [2:0]          cfg_idx;
    logic [BRIGHT_W-1:0] bright_wr;

    logic                item_acc;
    logic                pix_we;
    logic                start_acc;
    logic                tick_acc;
    logic [PROD_W-1:0]   prod_r, prod_g, prod_b;
    logic [ROW_W-1:0]    wrow;
    logic [LED_AW-1:0]   waddr;
    logic [ROW_W-1:0]    rdata;
    logic [ROW_W-1:0]    arr_row;
    logic [ROW_W-1:0]    cur_eff, nxt_eff;

    logic [TICK_W-1:0]   high_cnt, per_cnt;
    logic                bit_end, byte_end, led_end, frame_end, led_adv;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_we    = psel & penable & pwrite;
    assign cfg_idx   = paddr[CFG_AW-1:2];
    assign bright_wr = pwdata[BRIGHT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg   <= RST_ZERO_HIGH;
            zero_period_reg <= RST_ZERO_PERIOD;
            one_high_reg    <= RST_ONE_HIGH;
            one_period_reg  <= RST_ONE_PERIOD;
            latch_reg       <= RST_LATCH;
            bright_reg      <= RST_BRIGHTNESS;
            factor_reg      <= RST_FACTOR;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ZERO_HIGH:   zero_high_reg   <= pwdata[TICK_W-1:0];
                REG_ZERO_PERIOD: zero_period_reg <= pwdata[TICK_W-1:0];
                REG_ONE_HIGH:    one_high_reg    <= pwdata[TICK_W-1:0];
                REG_ONE_PERIOD:  one_period_reg  <= pwdata[TICK_W-1:0];
                REG_LATCH:       latch_reg       <= pwdata[TICK_W-1:0];
                REG_BRIGHTNESS:
                begin
                    // Values above full scale are dropped.
                    if (32'(bright_wr) <= 32'(BRIGHT_MAX))
                    begin
                        bright_reg <= bright_wr;
                        factor_reg <= FACTOR_W'(bright_wr) * FACTOR_W'(BRIGHT_RECIP);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ZERO_HIGH:   prdata = CFG_DW'(zero_high_reg);
            REG_ZERO_PERIOD: prdata = CFG_DW'(zero_period_reg);
            REG_ONE_HIGH:    prdata = CFG_DW'(one_high_reg);
            REG_ONE_PERIOD:  prdata = CFG_DW'(one_period_reg);
            REG_LATCH:       prdata = CFG_DW'(latch_reg);
            REG_BRIGHTNESS:  prdata = CFG_DW'(bright_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Item decode and pixel scaling
    // ------------------------------------------------------------------
    assign item_stall = res_vld_reg & result_stall;
    assign item_acc   = item_valid & ~item_stall;
    assign pix_we     = item_acc & (cmd == CMD_WRITE) & (32'(led_index) < 32'(LED_TOTAL));
    assign start_acc  = item_acc & (cmd == CMD_START) & (phase_reg == PH_IDLE);
    assign tick_acc   = item_acc & (cmd == CMD_TICK);

    assign prod_r = PROD_W'(red_in)   * PROD_W'(factor_reg);
    assign prod_g = PROD_W'(green_in) * PROD_W'(factor_reg);
    assign prod_b = PROD_W'(blue_in)  * PROD_W'(factor_reg);
    assign wrow   = {prod_r[BRIGHT_SHIFT+CH_W-1:BRIGHT_SHIFT],
                     prod_g[BRIGHT_SHIFT+CH_W-1:BRIGHT_SHIFT],
                     prod_b[BRIGHT_SHIFT+CH_W-1:BRIGHT_SHIFT]};
    assign waddr  = LED_AW'(led_index);

    srgbld_ram #(
        .WIDTH (ROW_W),
        .DEPTH (LED_TOTAL)
    ) u_store (
        .clk   (clk),
        .we    (pix_we),
        .waddr (waddr),
        .wdata (wrow),
        .raddr (rd_addr_next),
        .rdata (rdata)
    );

    // ------------------------------------------------------------------
    // Row fetch. A returning read is merged with a write of the same row
    // in this cycle or in the cycle the read was issued.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (pix_we && (waddr == rd_addr_reg))
        begin
            arr_row = wrow;
        end
        else if (ovr_reg)
        begin
            arr_row = cur_pend_reg ? cur_row_reg : nxt_row_reg;
        end
        else if (row_vld_reg[rd_addr_reg])
        begin
            arr_row = rdata;
        end
        else
        begin
            arr_row = '0;
        end
    end

    assign cur_eff = cur_pend_reg ? arr_row : cur_row_reg;
    assign nxt_eff = nxt_pend_reg ? arr_row : nxt_row_reg;

    // ------------------------------------------------------------------
    // Bit timer
    // ------------------------------------------------------------------
    assign high_cnt  = cur_bit_reg ? one_high_reg   : zero_high_reg;
    assign per_cnt   = cur_bit_reg ? one_period_reg : zero_period_reg;
    assign bit_end   = (tick_reg >= per_cnt);
    assign byte_end  = bit_end & (bit_reg == 3'd0);
    assign led_end   = byte_end & (col_reg == COL_BLUE);
    assign frame_end = led_end & (led_reg == LED_AW'(LED_TOTAL - 1));
    assign led_adv   = tick_acc & (phase_reg == PH_BITS) & led_end & ~frame_end;

    always_comb
    begin
        phase_next   = phase_reg;
        led_next     = led_reg;
        col_next     = col_reg;
        bit_next     = bit_reg;
        tick_next    = tick_reg;
        cur_bit_next = cur_bit_reg;
        line_next    = line_reg;
        done_next    = 1'b0;

        if (start_acc)
        begin
            led_next     = '0;
            col_next     = COL_RED;
            bit_next     = 3'd7;
            tick_next    = '0;
            phase_next   = PH_BITS;
            line_next    = 1'b0;
            cur_bit_next = 1'b0;
        end
        else if (tick_acc)
        begin
            case (phase_reg)
                PH_BITS:
                begin
                    line_next = (tick_reg < high_cnt);
                    if (bit_end)
                    begin
                        tick_next = '0;
                        if (bit_reg == 3'd0)
                        begin
                            bit_next = 3'd7;
                            if (col_reg == COL_BLUE)
                            begin
                                col_next = COL_RED;
                                led_next = led_reg + LED_AW'(1);
                            end
                            else
                            begin
                                col_next = col_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            bit_next = bit_reg - 3'd1;
                        end
                        if (frame_end)
                        begin
                            phase_next   = PH_LATCH;
                            cur_bit_next = 1'b0;
                        end
                        else
                        begin
                            // A new LED always starts on bit seven, which is
                            // zero, so the current row serves every load.
                            cur_bit_next = row_bit(cur_eff, col_next, bit_next);
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg + TICK_W'(1);
                    end
                end
                PH_LATCH:
                begin
                    line_next = 1'b0;
                    if (tick_reg >= latch_reg)
                    begin
                        tick_next  = '0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_reg + TICK_W'(1);
                    end
                end
                default:
                begin
                    line_next = 1'b0;
                end
            endcase
        end
    end

    // Read issue: LED 0 on start, then LED 1 once it is in, then the LED after
    // the next one whenever the frame moves on to a new LED.
    always_comb
    begin
        rd_addr_next  = led_reg + LED_AW'(1);
        cur_pend_next = 1'b0;
        nxt_pend_next = 1'b0;
        if (start_acc)
        begin
            rd_addr_next  = '0;
            cur_pend_next = 1'b1;
        end
        else if (cur_pend_reg)
        begin
            rd_addr_next  = led_reg + LED_AW'(1);
            nxt_pend_next = 1'b1;
        end
        else if (led_adv)
        begin
            rd_addr_next  = led_reg + LED_AW'(2);
            nxt_pend_next = 1'b1;
        end
        ovr_next = pix_we & (waddr == rd_addr_next);
    end

    always_comb
    begin
        cur_row_next = cur_row_reg;
        nxt_row_next = nxt_row_reg;
        if (cur_pend_reg)
        begin
            cur_row_next = arr_row;
        end
        if (led_adv)
        begin
            cur_row_next = nxt_eff;
        end
        if (pix_we && (waddr == led_reg))
        begin
            cur_row_next = wrow;
        end
        if (nxt_pend_reg)
        begin
            nxt_row_next = arr_row;
        end
        if (pix_we && (waddr == led_reg + LED_AW'(1)))
        begin
            nxt_row_next = wrow;
        end
    end

    assign res_vld_next = item_acc | (res_vld_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            led_reg      <= '0;
            col_reg      <= COL_RED;
            bit_reg      <= 3'd7;
            tick_reg     <= '0;
            cur_bit_reg  <= 1'b0;
            line_reg     <= 1'b0;
            done_reg     <= 1'b0;
            res_vld_reg  <= 1'b0;
            cur_pend_reg <= 1'b0;
            nxt_pend_reg <= 1'b0;
            ovr_reg      <= 1'b0;
            row_vld_reg  <= '0;
        end
        else
        begin
            if (item_acc)
            begin
                phase_reg   <= phase_next;
                led_reg     <= led_next;
                col_reg     <= col_next;
                bit_reg     <= bit_next;
                tick_reg    <= tick_next;
                cur_bit_reg <= cur_bit_next;
                line_reg    <= line_next;
                done_reg    <= done_next;
            end
            res_vld_reg  <= res_vld_next;
            cur_pend_reg <= cur_pend_next;
            nxt_pend_reg <= nxt_pend_next;
            ovr_reg      <= ovr_next;
            if (pix_we)
            begin
                row_vld_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg <= cur_row_next;
        nxt_row_reg <= nxt_row_next;
        rd_addr_reg <= rd_addr_next;
    end

    assign result_valid = res_vld_reg;
    assign line_level   = line_reg;
    assign busy_res     = (phase_reg != PH_IDLE);
    assign frame_done   = done_reg;

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial RGB LED chain driver. A queue-fed driver
// offers pixel writes, frame starts and timer ticks, while a monitor checks
// every result transfer against a cycle-free model of the waveform generator.
// Timing and brightness registers are reprogrammed over APB between phases,
// including mid-frame, with both sides idling and stalling at random.
// ---------------------------------------------------------------------------
module tb_top;
    import srgbld_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RUN_LIMIT = 4000000;
    localparam int LONG_HOLD = 300;
    localparam int BYTE_COUNT = 3 * LED_TOTAL;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } led_item_t;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic frame_done;
    } chain_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] cmd = CMD_WRITE;
    logic [5:0] led_index = '0;
    logic [7:0] red_in = '0;
    logic [7:0] green_in = '0;
    logic [7:0] blue_in = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    serial_rgb_led_chain_driver i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .led_index    (led_index),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .line_level   (line_level),
        .busy_res     (busy_res),
        .frame_done   (frame_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Shadow of the configuration registers.
    logic [15:0] zero_high;
    logic [15:0] zero_per;
    logic [15:0] one_high;
    logic [15:0] one_per;
    logic [15:0] latch_len;
    logic [6:0]  brightness;

    // Shadow of the pixel store and the transmitter.
    logic [7:0]  led_bytes [0:BYTE_COUNT-1];
    int          byte_pos;
    logic [2:0]  bit_num;
    logic [15:0] tick_cnt;
    phase_t      tx_phase;
    logic        cur_bit;
    logic        line_hold;

    led_item_t   pending_items[$];
    chain_out_t  awaited_outputs[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_requests = 0;
    int  holds_served = 0;
    bit  sender_gaps_on = 1'b1;
    bit  receiver_stalls_on = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] scale_colour(input logic [7:0] c);
        return 8'((int'(c) * int'(brightness)) / 200);
    endfunction

    function automatic void load_next_bit();
        if (byte_pos >= BYTE_COUNT)
            cur_bit = 1'b0;
        else
            cur_bit = led_bytes[byte_pos][bit_num];
    endfunction

    // Applies one item to the shadow state and returns the result it causes.
    function automatic chain_out_t advance_chain(input led_item_t it);
        chain_out_t o;
        logic [15:0] hi;
        logic [15:0] per;
        int base;
        o.frame_done = 1'b0;
        case (it.cmd)
            CMD_WRITE:
            begin
                if (int'(it.led_index) < LED_TOTAL)
                begin
                    base = 3 * int'(it.led_index);
                    led_bytes[base]     = scale_colour(it.red);
                    led_bytes[base + 1] = scale_colour(it.green);
                    led_bytes[base + 2] = scale_colour(it.blue);
                end
            end
            CMD_START:
            begin
                if (tx_phase == PH_IDLE)
                begin
                    byte_pos  = 0;
                    bit_num   = 3'd7;
                    tick_cnt  = '0;
                    tx_phase  = PH_BITS;
                    line_hold = 1'b0;
                    load_next_bit();
                end
            end
            CMD_TICK:
            begin
                if (tx_phase == PH_BITS)
                begin
                    hi  = cur_bit ? one_high : zero_high;
                    per = cur_bit ? one_per : zero_per;
                    line_hold = (tick_cnt < hi);
                    if (tick_cnt >= per)
                    begin
                        tick_cnt = '0;
                        if (bit_num == 3'd0)
                        begin
                            bit_num = 3'd7;
                            byte_pos++;
                        end
                        else
                            bit_num--;
                        if (byte_pos >= BYTE_COUNT)
                        begin
                            tx_phase = PH_LATCH;
                            cur_bit  = 1'b0;
                        end
                        else
                            load_next_bit();
                    end
                    else
                        tick_cnt++;
                end
                else if (tx_phase == PH_LATCH)
                begin
                    line_hold = 1'b0;
                    if (tick_cnt >= latch_len)
                    begin
                        tick_cnt     = '0;
                        tx_phase     = PH_IDLE;
                        o.frame_done = 1'b1;
                    end
                    else
                        tick_cnt++;
                end
                else
                    line_hold = 1'b0;
            end
            default: ;
        endcase
        o.line_level = line_hold;
        o.busy = (tx_phase != PH_IDLE);
        return o;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] pick_colour();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_timing(input bit nonzero);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(nonzero ? 1 : 0, 6));
        else if (r < 80)
            return 16'hFFFF;
        else if (r < 88)
            return nonzero ? 16'd1 : 16'd0;
        else
            return 16'($urandom_range(nonzero ? 1 : 0, 65535));
    endfunction

    function automatic led_item_t random_item(input int tick_pct);
        led_item_t it;
        int r;
        it.led_index = 6'($urandom_range(0, 63));
        it.red   = pick_colour();
        it.green = pick_colour();
        it.blue  = pick_colour();
        if ($urandom_range(0, 99) < tick_pct)
            it.cmd = CMD_TICK;
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                it.cmd = CMD_WRITE;
            else if (r < 8)
                it.cmd = CMD_START;
            else
                it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        mismatch_count++;
        $display("MISMATCH at cycle %0d: %s expected %0d, got %0d",
                 cycle_count, what, want_v, got_v);
    endtask

    task automatic queue_item(input logic [1:0] c, input int idx, input int r,
                              input int g, input int b);
        pending_items.push_back({c, 6'(idx), 8'(r), 8'(g), 8'(b)});
    endtask

    // A setup phase, then an access phase; the register takes the value at the
    // edge that completes the access.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ZERO_HIGH:   zero_high = value[15:0];
            REG_ZERO_PERIOD: zero_per  = value[15:0];
            REG_ONE_HIGH:    one_high  = value[15:0];
            REG_ONE_PERIOD:  one_per   = value[15:0];
            REG_LATCH:       latch_len = value[15:0];
            REG_BRIGHTNESS:  if (value[6:0] <= 7'(BRIGHT_MAX)) brightness = value[6:0];
            default: ;
        endcase
    endtask

    // Sampled on the falling edge so that the queues and valid have settled.
    task automatic wait_quiet();
        while (pending_items.size() != 0 || item_valid || awaited_outputs.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : feed_items
        led_item_t nxt;
        led_item_t taken;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                taken = {cmd, led_index, red_in, green_in, blue_in};
                awaited_outputs.push_back(advance_chain(taken));
            end
            // A stalled transfer keeps its payload until it is taken.
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    nxt = pending_items.pop_front();
                    item_valid <= 1'b1;
                    cmd        <= nxt.cmd;
                    led_index  <= nxt.led_index;
                    red_in     <= nxt.red;
                    green_in   <= nxt.green;
                    blue_in    <= nxt.blue;
                    gap_left = sender_gaps_on ? pick_gap() : 0;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_results
        chain_out_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_outputs.size() == 0)
                    report_mismatch("result with nothing awaited, line_level", 0, line_level);
                else
                begin
                    want = awaited_outputs.pop_front();
                    if (line_level !== want.line_level)
                        report_mismatch("line_level", want.line_level, line_level);
                    if (busy_res !== want.busy)
                        report_mismatch("busy_res", want.busy, busy_res);
                    if (frame_done !== want.frame_done)
                        report_mismatch("frame_done", want.frame_done, frame_done);
                end
            end
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stall_left == 0 && receiver_stalls_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int ph;
        int n;
        int ticks;
        led_item_t it;

        zero_high  = RST_ZERO_HIGH;
        zero_per   = RST_ZERO_PERIOD;
        one_high   = RST_ONE_HIGH;
        one_per    = RST_ONE_PERIOD;
        latch_len  = RST_LATCH;
        brightness = RST_BRIGHTNESS;
        for (n = 0; n < BYTE_COUNT; n++)
            led_bytes[n] = 8'h00;
        byte_pos  = 0;
        bit_num   = 3'd7;
        tick_cnt  = '0;
        tx_phase  = PH_IDLE;
        cur_bit   = 1'b0;
        line_hold = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_ZERO_HIGH, 32'd1);
        write_reg(REG_ZERO_PERIOD, 32'd3);
        write_reg(REG_ONE_HIGH, 32'd3);
        write_reg(REG_ONE_PERIOD, 32'd5);
        write_reg(REG_LATCH, 32'd4);

        // Full-scale and extreme writes, an unknown command, a tick while idle,
        // then a frame with a pixel write and a second start while it runs.
        queue_item(CMD_WRITE, 0, 255, 255, 255);
        queue_item(CMD_WRITE, 63, 128, 1, 254);
        queue_item(CMD_UNUSED, 63, 255, 255, 255);
        queue_item(CMD_TICK, 0, 0, 0, 0);
        queue_item(CMD_START, 0, 0, 0, 0);
        queue_item(CMD_TICK, 0, 0, 0, 0);
        queue_item(CMD_WRITE, 0, 0, 255, 0);
        queue_item(CMD_START, 0, 0, 0, 0);
        repeat (8) queue_item(CMD_TICK, 0, 0, 0, 0);
        hold_requests++;
        wait_quiet();

        // Brightness above the maximum must leave the old setting in place.
        write_reg(REG_BRIGHTNESS, 32'd101);
        write_reg(REG_BRIGHTNESS, 32'd127);
        queue_item(CMD_WRITE, 1, 255, 200, 3);
        wait_quiet();
        write_reg(REG_BRIGHTNESS, 32'd0);
        queue_item(CMD_WRITE, 2, 255, 255, 255);
        wait_quiet();
        write_reg(REG_BRIGHTNESS, 32'd100);

        // Huge slots with the zero high count equal to the period, then the periods
        // are cut below the running count so the slot must end at once.
        write_reg(REG_ZERO_PERIOD, 32'hFFFF);
        write_reg(REG_ONE_PERIOD, 32'hFFFF);
        write_reg(REG_ZERO_HIGH, 32'hFFFF);
        write_reg(REG_ONE_HIGH, 32'd0);
        repeat (4) queue_item(CMD_TICK, 0, 0, 0, 0);
        wait_quiet();
        write_reg(REG_ZERO_PERIOD, 32'd1);
        write_reg(REG_ONE_PERIOD, 32'd1);
        repeat (3) queue_item(CMD_TICK, 0, 0, 0, 0);
        wait_quiet();

        for (ph = 0; ph < 8; ph++)
        begin
            sender_gaps_on     = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            if (ph == 4)
            begin
                // One tick per bit and a short latch, with enough ticks to run
                // a whole frame out.
                write_reg(REG_ZERO_PERIOD, 32'd0);
                write_reg(REG_ONE_PERIOD, 32'd0);
                write_reg(REG_ZERO_HIGH, 32'($urandom_range(0, 2)));
                write_reg(REG_ONE_HIGH, 32'($urandom_range(0, 2)));
                write_reg(REG_LATCH, 32'($urandom_range(1, 6)));
                queue_item(CMD_START, 0, 0, 0, 0);
                ticks = 0;
                while (ticks < BYTE_COUNT * 8 + 8)
                begin
                    it = random_item(99);
                    if (it.cmd == CMD_TICK)
                        ticks++;
                    pending_items.push_back(it);
                end
            end
            else
            begin
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_ZERO_HIGH, 32'(pick_timing(1'b0)));
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_ZERO_PERIOD, 32'(pick_timing(1'b1)));
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_ONE_HIGH, 32'(pick_timing(1'b0)));
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_ONE_PERIOD, 32'(pick_timing(1'b1)));
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_LATCH, 32'(pick_timing(1'b1)));
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_BRIGHTNESS, 32'($urandom_range(0, 127)));
                n = $urandom_range(4, 10);
                repeat (n) pending_items.push_back(random_item(60));
            end
            if (ph % 3 == 1)
                hold_requests++;
            wait_quiet();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && awaited_outputs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/srgbld_pkg.sv
rtl/srgbld_ram.sv
rtl/serial_rgb_led_chain_driver.sv
tb/sv/tb_top.sv
